/* hw/rtl/tdcrb_pkg.sv */
// ----------------------------------------------------------------------------
// tdcrb_pkg
// Shared types and constants for the readout block-chain checker.
// ----------------------------------------------------------------------------
`default_nettype none

package tdcrb_pkg;

  localparam int MAX_CARDS_DEF = 256;

  typedef logic [1:0] status_t;
  typedef logic [3:0] cause_t;
  typedef logic [3:0] phase_t;

  // status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_MISSING = 2'd1;
  localparam status_t ST_CORRUPT = 2'd2;

  // cause codes
  localparam cause_t CAUSE_NONE          = 4'd0;
  localparam cause_t CAUSE_SHORT_HEADER  = 4'd1;
  localparam cause_t CAUSE_MARKER        = 4'd2;
  localparam cause_t CAUSE_TRIGGER       = 4'd3;
  localparam cause_t CAUSE_LINK          = 4'd4;
  localparam cause_t CAUSE_CARD          = 4'd5;
  localparam cause_t CAUSE_CHANNEL       = 4'd6;
  localparam cause_t CAUSE_EVENT_COUNT   = 4'd7;
  localparam cause_t CAUSE_MISMATCH      = 4'd8;
  localparam cause_t CAUSE_SHORT_PAYLOAD = 4'd9;

  // block phases: header word expected next, or payload
  localparam phase_t PHASE_WORD0   = 4'd0;
  localparam phase_t PHASE_EVCNT   = 4'd2;
  localparam phase_t PHASE_MATCH   = 4'd6;
  localparam phase_t PHASE_LENGTH  = 4'd7;
  localparam phase_t PHASE_PAYLOAD = 4'd8;

  // header field constants
  localparam logic [7:0]  HDR_MARKER    = 8'h34;
  localparam logic [7:0]  CHAN_NO_COUNT = 8'hff;
  localparam logic [7:0]  CHAN_LIMIT    = 8'd16;
  localparam logic [15:0] COUNT_SAT     = 16'hffff;

  // configuration register indexes
  localparam logic [1:0] CFG_TRIGGER     = 2'd0;
  localparam logic [1:0] CFG_LINK        = 2'd1;
  localparam logic [1:0] CFG_CARD_COUNT  = 2'd2;
  localparam logic [1:0] CFG_EVENT_COUNT = 2'd3;

  typedef struct packed {
    logic [3:0]  expected_trigger;
    logic [1:0]  link_id;
    logic [8:0]  card_count;
    logic [15:0] expected_event_count;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    cause_t      cause;
    logic [15:0] blocks_done;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/tdcrb_word0_check.sv */
// ----------------------------------------------------------------------------
// tdcrb_word0_check
// Field checks on header word 0, first fault wins.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrb_word0_check #(
  parameter int MAX_CARDS = tdcrb_pkg::MAX_CARDS_DEF
) (
  input  tdcrb_pkg::cfg_t   cfg,
  input  logic [31:0]       word,
  output tdcrb_pkg::cause_t cause
);
  import tdcrb_pkg::*;

  localparam logic [8:0] CardCap = 9'(MAX_CARDS);

  logic [8:0] card_limit;
  logic [7:0] channel;

  assign card_limit = (cfg.card_count > CardCap) ? CardCap : cfg.card_count;
  assign channel    = word[31:24];

  // priority: marker, trigger, link, card, channel
  always_comb begin
    if (word[7:0] != HDR_MARKER) begin
      cause = CAUSE_MARKER;
    end else if (word[11:8] != cfg.expected_trigger) begin
      cause = CAUSE_TRIGGER;
    end else if (word[15:12] != {2'b00, cfg.link_id}) begin
      cause = CAUSE_LINK;
    end else if ({1'b0, word[23:16]} >= card_limit) begin
      cause = CAUSE_CARD;
    end else if (channel >= CHAN_LIMIT && channel != CHAN_NO_COUNT) begin
      cause = CAUSE_CHANNEL;
    end else begin
      cause = CAUSE_NONE;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tdcrb_parser.sv */
// ----------------------------------------------------------------------------
// tdcrb_parser
// Block-chain parse state, updated once per word; builds the buffer status.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrb_parser #(
  parameter int MAX_CARDS = tdcrb_pkg::MAX_CARDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [31:0]        word,
  input  logic               last,
  input  tdcrb_pkg::cfg_t    cfg,
  output tdcrb_pkg::result_t result
);
  import tdcrb_pkg::*;

  phase_t      phase,        phase_next;
  logic [29:0] payload_left, payload_left_next;
  logic [23:0] saved_header, saved_header_next;
  cause_t      pending,      pending_next;
  logic        err,          err_next;
  cause_t      final_cause,  final_cause_next;
  logic [15:0] blocks,       blocks_next;
  logic        skip_count,   skip_count_next;

  cause_t      w0_cause;
  logic [29:0] left_dec;
  logic        done;   // block completes on this word

  tdcrb_word0_check #(
    .MAX_CARDS (MAX_CARDS)
  ) u_w0 (
    .cfg   (cfg),
    .word  (word),
    .cause (w0_cause)
  );

  assign left_dec = payload_left - 30'd1;

  always_comb begin
    phase_next        = phase;
    payload_left_next = payload_left;
    saved_header_next = saved_header;
    pending_next      = pending;
    err_next          = err;
    final_cause_next  = final_cause;
    blocks_next       = blocks;
    skip_count_next   = skip_count;
    done              = 1'b0;

    if (!err) begin
      if (phase == PHASE_PAYLOAD) begin
        payload_left_next = left_dec;
        done              = (left_dec == '0);
      end else begin
        phase_next = phase + 4'd1;
        case (phase)
          PHASE_WORD0: begin
            saved_header_next = word[23:0];
            skip_count_next   = (word[31:24] == CHAN_NO_COUNT);
            pending_next      = w0_cause;
          end
          PHASE_EVCNT: begin
            if (pending == CAUSE_NONE && !skip_count &&
                word[15:0] != cfg.expected_event_count) begin
              pending_next = CAUSE_EVENT_COUNT;
            end
          end
          PHASE_MATCH: begin
            if (pending == CAUSE_NONE && word[23:0] != saved_header) begin
              pending_next = CAUSE_MISMATCH;
            end
          end
          PHASE_LENGTH: begin
            if (pending != CAUSE_NONE) begin
              err_next         = 1'b1;
              final_cause_next = pending;
              phase_next       = phase;
            end else begin
              payload_left_next = word[31:2];
              phase_next        = PHASE_PAYLOAD;
              done              = (word[31:2] == '0);
            end
          end
          default: begin
          end
        endcase
      end
      if (done) begin
        blocks_next     = (blocks != COUNT_SAT) ? blocks + 16'd1 : blocks;
        phase_next      = PHASE_WORD0;
        pending_next    = CAUSE_NONE;
        skip_count_next = 1'b0;
      end
    end

    // status from the state after this word
    result.blocks_done = blocks_next;
    if (err_next) begin
      result.cause  = final_cause_next;
      result.status = (final_cause_next == CAUSE_SHORT_HEADER ||
                       final_cause_next == CAUSE_SHORT_PAYLOAD) ? ST_MISSING : ST_CORRUPT;
    end else if (phase_next == PHASE_WORD0) begin
      result.status = ST_OK;
      result.cause  = CAUSE_NONE;
    end else if (phase_next == PHASE_PAYLOAD) begin
      result.status = ST_MISSING;
      result.cause  = CAUSE_SHORT_PAYLOAD;
    end else begin
      result.status = ST_MISSING;
      result.cause  = CAUSE_SHORT_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (en && last)) begin
      phase        <= PHASE_WORD0;
      payload_left <= '0;
      saved_header <= '0;
      pending      <= CAUSE_NONE;
      err          <= 1'b0;
      final_cause  <= CAUSE_NONE;
      blocks       <= '0;
      skip_count   <= 1'b0;
    end else if (en) begin
      phase        <= phase_next;
      payload_left <= payload_left_next;
      saved_header <= saved_header_next;
      pending      <= pending_next;
      err          <= err_next;
      final_cause  <= final_cause_next;
      blocks       <= blocks_next;
      skip_count   <= skip_count_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tdc_readout_block_checker_core.sv */
// ----------------------------------------------------------------------------
// tdc_readout_block_checker_core
// Checks an event buffer streamed one word per transfer as a chain of
// 8-word-header blocks and reports one status on the last word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                     | handshake
//  ---------+-----+---------------------------------------------+-------------
//  s_axis   | in  | tdata[31:0] word, tlast = last word         | tvalid/tready
//  m_axis   | out | tdata: status[1:0] cause[5:2] blocks[21:6]  | tvalid/tready
//  cfg      | in  | cfg_addr register index, cfg_data value     | cfg_we
//
//  One word per cycle sustained while the result side is not stalled. A word
//  sits in the input register until the output slot is free; at that edge the
//  parser updates and a last word's status lands in the output register, which
//  drives the result stream.
//  The output register only loads when empty or being taken, so a stalled
//  result holds the parser and, once the input register fills, s_axis_tready.
//  Reset (rst, synchronous) clears both stages, the parse state and the
//  registers to their defaults (card_count = 1, others 0).
//
`default_nettype none

module tdc_readout_block_checker_core #(
  parameter int MAX_CARDS = tdcrb_pkg::MAX_CARDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_word
  input  logic        s_axis_tlast,   // last_word
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] status, [5:2] cause, [21:6] blocks_done
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import tdcrb_pkg::*;

  cfg_t        cfg;

  // input register
  logic        in_valid;
  logic [31:0] in_word;
  logic        in_last;

  // output register
  result_t     res;
  result_t     res_next;

  logic        advance;   // output slot free at this edge
  logic        proc;      // input-register word consumed by the parser

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign proc          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_trigger     <= '0;
      cfg.link_id              <= '0;
      cfg.card_count           <= 9'd1;
      cfg.expected_event_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TRIGGER:     cfg.expected_trigger     <= cfg_data[3:0];
        CFG_LINK:        cfg.link_id              <= cfg_data[1:0];
        CFG_CARD_COUNT:  cfg.card_count           <= cfg_data[8:0];
        CFG_EVENT_COUNT: cfg.expected_event_count <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // input stage: refills whenever its word moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_word <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  tdcrb_parser #(
    .MAX_CARDS (MAX_CARDS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .en     (proc),
    .word   (in_word),
    .last   (in_last),
    .cfg    (cfg),
    .result (res_next)
  );

  // result register: only the last word of a buffer yields a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= proc && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = {2'b00, res.blocks_done, res.cause, res.status};

endmodule

`default_nettype wire

/* hw/rtl/tdcrb_checker.sv */
// ----------------------------------------------------------------------------
// tdcrb_checker
// Port-level assertions for the block-chain checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import tdcrb_pkg::*;

  status_t st;
  cause_t  cs;

  assign st = m_axis_tdata[1:0];
  assign cs = m_axis_tdata[5:2];

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // ok status exactly when no cause
  a_ok_cause: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((st == ST_OK) == (cs == CAUSE_NONE)))
    else $error("status and cause disagree");

  // missing data only for a short header or payload
  a_missing: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st == ST_MISSING |->
      cs == CAUSE_SHORT_HEADER || cs == CAUSE_SHORT_PAYLOAD)
    else $error("missing status with corrupt cause");

endmodule

bind tdc_readout_block_checker_core tdcrb_checker u_tdcrb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* tb/tb_tdc_readout_block_checker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tdc_readout_block_checker_core
// Streams event buffers (chains of 8-word-header blocks) into the checker and
// compares every status transfer against a cycle-free predictor of the parser.
// Buffers are mostly well-formed chains with random content, with injected
// header faults, truncations and noise, under several register settings and
// several idle patterns on both stream sides.
// ----------------------------------------------------------------------------
module tb_tdc_readout_block_checker_core;
  import tdcrb_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 3000;
  // Settling time once every queued status is back.
  localparam int DRAIN_CYCLES = 4;

  // --------------------------------------------------------------------------
  // Predictor and result store
  // --------------------------------------------------------------------------
  class status_scoreboard;
    cfg_t    cfg;
    result_t expected_q[$];
    int      errors;
    int      results_checked;
    int      cause_hits[16];

    // parser state
    phase_t      hdr_idx;       // header word expected next, or payload
    logic [29:0] words_owed;    // payload words still due
    logic [23:0] hdr_low;       // low 24 bits of header word 0
    cause_t      held_cause;    // first header fault of the current block
    bit          aborted;
    cause_t      abort_cause;
    logic [15:0] whole_blocks;
    bit          no_count_chk;  // channel 0xff: event count not checked

    function new();
      cfg.expected_trigger     = '0;
      cfg.link_id              = '0;
      cfg.card_count           = 9'd1;
      cfg.expected_event_count = '0;
      restart();
    endfunction

    function void restart();
      hdr_idx      = PHASE_WORD0;
      words_owed   = '0;
      hdr_low      = '0;
      held_cause   = CAUSE_NONE;
      aborted      = 1'b0;
      abort_cause  = CAUSE_NONE;
      whole_blocks = '0;
      no_count_chk = 1'b0;
    endfunction

    function void close_block();
      if (whole_blocks != COUNT_SAT) whole_blocks++;
      hdr_idx      = PHASE_WORD0;
      held_cause   = CAUSE_NONE;
      no_count_chk = 1'b0;
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_TRIGGER:     cfg.expected_trigger     = val[3:0];
        CFG_LINK:        cfg.link_id              = val[1:0];
        CFG_CARD_COUNT:  cfg.card_count           = val[8:0];
        CFG_EVENT_COUNT: cfg.expected_event_count = val[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // One accepted input transfer; a last word queues exactly one status.
    function void note_word(logic [31:0] w, logic last);
      logic [8:0] lim;
      logic [7:0] chan;
      result_t    r;
      if (!aborted) begin
        if (hdr_idx == PHASE_PAYLOAD) begin
          words_owed = words_owed - 1'b1;
          if (words_owed == '0) close_block();
        end else begin
          case (hdr_idx)
            PHASE_WORD0: begin
              lim  = (cfg.card_count > MAX_CARDS_DEF) ? 9'(MAX_CARDS_DEF) : cfg.card_count;
              chan = w[31:24];
              hdr_low      = w[23:0];
              no_count_chk = (chan == CHAN_NO_COUNT);
              // checked in this order; the first fault wins
              if (w[7:0] != HDR_MARKER)                          held_cause = CAUSE_MARKER;
              else if (w[11:8] != cfg.expected_trigger)          held_cause = CAUSE_TRIGGER;
              else if (w[15:12] != {2'b00, cfg.link_id})         held_cause = CAUSE_LINK;
              else if ({1'b0, w[23:16]} >= lim)                  held_cause = CAUSE_CARD;
              else if (chan >= CHAN_LIMIT && chan != CHAN_NO_COUNT) held_cause = CAUSE_CHANNEL;
              else                                               held_cause = CAUSE_NONE;
            end
            PHASE_EVCNT:
              if (held_cause == CAUSE_NONE && !no_count_chk &&
                  w[15:0] != cfg.expected_event_count)
                held_cause = CAUSE_EVENT_COUNT;
            PHASE_MATCH:
              if (held_cause == CAUSE_NONE && w[23:0] != hdr_low)
                held_cause = CAUSE_MISMATCH;
            default: ;
          endcase
          if (hdr_idx == PHASE_LENGTH) begin
            // header faults surface only once the length word is in
            if (held_cause != CAUSE_NONE) begin
              aborted     = 1'b1;
              abort_cause = held_cause;
            end else begin
              words_owed = w[31:2];
              if (words_owed == '0) close_block();
              else hdr_idx = PHASE_PAYLOAD;
            end
          end else begin
            hdr_idx = hdr_idx + 1'b1;
          end
        end
      end
      if (last) begin
        if (aborted) begin
          r.status = ST_CORRUPT;
          r.cause  = abort_cause;
        end else if (hdr_idx == PHASE_WORD0) begin
          r.status = ST_OK;
          r.cause  = CAUSE_NONE;
        end else if (hdr_idx == PHASE_PAYLOAD) begin
          r.status = ST_MISSING;
          r.cause  = CAUSE_SHORT_PAYLOAD;
        end else begin
          r.status = ST_MISSING;
          r.cause  = CAUSE_SHORT_HEADER;
        end
        r.blocks_done = whole_blocks;
        cause_hits[r.cause]++;
        expected_q.push_back(r);
        restart();
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [23:0] d);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("status transfer %h with none expected", d));
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (d[1:0] != want.status)
        report($sformatf("status %0d, expected %0d", d[1:0], want.status));
      if (d[5:2] != want.cause)
        report($sformatf("cause %0d, expected %0d", d[5:2], want.cause));
      if (d[21:6] != want.blocks_done)
        report($sformatf("blocks_done %0d, expected %0d", d[21:6], want.blocks_done));
      if (d[23:22] != 2'b00)
        report($sformatf("tdata pad bits %b not zero", d[23:22]));
    endtask
  endclass

  typedef enum int {
    FAULT_NONE, FAULT_MARKER, FAULT_TRIGGER, FAULT_LINK,
    FAULT_CARD, FAULT_CHANNEL, FAULT_EVCNT, FAULT_MISMATCH
  } fault_t;

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] data_word
  logic        s_axis_tlast = 1'b0; // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [1:0] status, [5:2] cause, [21:6] blocks_done
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_TRIGGER;
  logic [15:0] cfg_data = '0;

  status_scoreboard sb = new();

  // idle odds in percent, changed per stimulus section
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent    = 0;
  int buffers_sent  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;

  logic [31:0] frame_words[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tdc_readout_block_checker_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // Receiver: random backpressure, one decision per cycle.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor: every status transfer is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog: a stretch with no transfer at all means the block is hung.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One input transfer; the predictor sees the word at the accepting edge.
  // Before offering the word the sender sits out cycles at the idle odds,
  // decided once per cycle.
  task send_word(input logic [31:0] w, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_word(w, last);
    words_sent++;
  endtask

  task send_frame();
    foreach (frame_words[i]) send_word(frame_words[i], i == frame_words.size() - 1);
    buffers_sent++;
  endtask

  // Stop sending until every queued status has come back, then let the
  // pipeline settle.
  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; lowered by the caller.
  task put_register(input logic [1:0] idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    sb.write_register(idx, val);
    @(posedge clk);
  endtask

  task write_registers(input logic [15:0] trig, input logic [15:0] link,
                       input logic [15:0] cards, input logic [15:0] evcnt);
    put_register(CFG_TRIGGER, trig);
    put_register(CFG_LINK, link);
    put_register(CFG_CARD_COUNT, cards);
    put_register(CFG_EVENT_COUNT, evcnt);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // Buffer generation
  // --------------------------------------------------------------------------

  // Appends one block matching the current registers, optionally with one
  // header fault. Payload is short most of the time.
  task append_block(input fault_t fault);
    logic [31:0] w0, w2, w6, w7;
    logic [8:0]  lim;
    int          n_pay;
    lim = (sb.cfg.card_count > MAX_CARDS_DEF) ? 9'(MAX_CARDS_DEF) : sb.cfg.card_count;
    w0[7:0]   = HDR_MARKER;
    w0[11:8]  = sb.cfg.expected_trigger;
    w0[15:12] = {2'b00, sb.cfg.link_id};
    w0[23:16] = (lim == 0) ? 8'($urandom) : 8'($urandom_range(0, lim - 1));
    w0[31:24] = ($urandom_range(0, 4) == 0) ? CHAN_NO_COUNT : 8'($urandom_range(0, 15));
    w2 = {16'($urandom), sb.cfg.expected_event_count};
    case (fault)
      FAULT_MARKER:  w0[7:0]   = HDR_MARKER ^ 8'($urandom_range(1, 255));
      FAULT_TRIGGER: w0[11:8]  = w0[11:8] ^ 4'($urandom_range(1, 15));
      // any nonzero flip, so nibbles of 4 and up show up too
      FAULT_LINK:    w0[15:12] = w0[15:12] ^ 4'($urandom_range(1, 15));
      FAULT_CARD:    if (lim < 256) w0[23:16] = 8'($urandom_range(lim, 255));
      FAULT_CHANNEL: w0[31:24] = 8'($urandom_range(16, 254));
      FAULT_EVCNT:   w2[15:0]  = w2[15:0] ^ 16'($urandom_range(1, 16'hffff));
      default: ;
    endcase
    w6 = {8'($urandom), w0[23:0]};
    if (fault == FAULT_MISMATCH) w6[23:0] = w6[23:0] ^ 24'($urandom_range(1, 24'hffffff));
    n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
    // now and then a wild byte count: the buffer then ends inside the payload
    w7 = ($urandom_range(0, 24) == 0) ? $urandom : 32'(n_pay * 4 + $urandom_range(0, 3));
    frame_words.push_back(w0);
    frame_words.push_back($urandom);
    frame_words.push_back(w2);
    repeat (3) frame_words.push_back($urandom);
    frame_words.push_back(w6);
    frame_words.push_back(w7);
    repeat (n_pay) frame_words.push_back($urandom);
  endtask

  // Half the buffers are clean chains; the rest carry one faulty block, get cut
  // short, or are plain noise.
  task build_frame();
    int roll, n_blocks, hit, keep;
    frame_words.delete();
    roll = $urandom_range(0, 99);
    if (roll >= 92) begin
      repeat ($urandom_range(1, 12))
        frame_words.push_back(($urandom_range(0, 1) == 1) ? $urandom
                              : {24'($urandom), HDR_MARKER});
    end else begin
      n_blocks = $urandom_range(1, 3);
      hit = (roll >= 50 && roll < 82) ? $urandom_range(0, n_blocks - 1) : -1;
      for (int b = 0; b < n_blocks; b++)
        append_block((b == hit) ? fault_t'($urandom_range(1, 7)) : FAULT_NONE);
      if (roll >= 82 && frame_words.size() > 1) begin
        keep = $urandom_range(1, frame_words.size() - 1);
        while (frame_words.size() > keep) void'(frame_words.pop_back());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int    phase_words;
    string hits;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: trigger 5, link 2, ten cards, event count 0x1234.
    write_registers(16'd5, 16'd2, 16'd10, 16'h1234);
    // single-word buffers of all ones and all zeros: header cut at word 0
    frame_words = '{32'hffff_ffff};
    send_frame();
    frame_words = '{32'h0000_0000};
    send_frame();
    // highest card, channel 0xff so the wrong event count is skipped, byte
    // count 3 rounds down to an empty payload: one complete block
    frame_words = '{{CHAN_NO_COUNT, 8'd9, 4'd2, 4'd5, HDR_MARKER}, 32'h0,
                    32'hffff_0000, 32'h0, 32'h0, 32'h0,
                    {8'h00, 8'd9, 4'd2, 4'd5, HDR_MARKER}, 32'd3};
    send_frame();
    // bad marker, but the buffer ends inside the header: missing wins
    frame_words = '{{8'd15, 8'd0, 4'd2, 4'd5, 8'h35}, 32'h0, 32'h1234, 32'h0};
    send_frame();
    // clean header, two payload words announced, only one delivered
    frame_words = '{{8'd15, 8'd0, 4'd2, 4'd5, HDR_MARKER}, 32'h5555_aaaa,
                    32'habcd_1234, 32'h0, 32'h0, 32'h0,
                    {8'hff, 8'd0, 4'd2, 4'd5, HDR_MARKER}, 32'd8, 32'hdead_beef};
    send_frame();

    // Random part: six register settings; first the sender idles lightly and
    // the receiver heavily, then the reverse, then full throughput.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: write_registers(16'd15, 16'd3, 16'd256, 16'hffff);
        // no cards at all: every header that passes marker, trigger and link fails on its card id
        1: write_registers(16'($urandom_range(0, 15)), 16'($urandom_range(0, 3)), 16'd0,
                           16'($urandom));
        2: write_registers(16'd0, 16'd0, 16'd1, 16'd0);
        // card count above the card limit is capped
        3: write_registers(16'($urandom_range(0, 15)), 16'($urandom_range(0, 3)), 16'd511,
                           16'($urandom));
        // junk in the unused upper bits of the write data
        4: write_registers(16'($urandom), 16'($urandom),
                           {7'($urandom), 9'($urandom_range(1, 256))}, 16'($urandom));
        default: write_registers(16'($urandom_range(0, 15)), 16'($urandom_range(0, 3)),
                                 16'($urandom_range(1, 256)), 16'($urandom));
      endcase
      send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 75 : 0;
      recv_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 30 : 0;
      phase_words = 0;
      while (phase_words < 100 || (ph == 5 && sb.results_checked + sb.pending() < 40)) begin
        build_frame();
        send_frame();
        phase_words += frame_words.size();
        // occasionally hold off until every status is back
        if ($urandom_range(0, 11) == 0) wait_drained();
      end
    end

    wait_drained();
    hits = "";
    for (int c = CAUSE_NONE; c <= CAUSE_SHORT_PAYLOAD; c++)
      hits = {hits, $sformatf(" %0d", sb.cause_hits[c])};
    $display("Run covered %0d words in %0d buffers under %0d register settings, %0d statuses.",
             words_sent, buffers_sent, settings_used, sb.results_checked);
    $display("Statuses per cause, none through short payload:%s", hits);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
